### hw/rtl/v3a_pkg.sv
`default_nettype none

package v3a_pkg;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_DOT     = 4'd4,
    OP_CROSS   = 4'd5,
    OP_LENSQ   = 4'd6,
    OP_LEN     = 4'd7,
    OP_NORM    = 4'd8,
    OP_ISZERO  = 4'd9,
    OP_TRIPLE  = 4'd10,
    OP_STRIPLE = 4'd11
  } op_e;

  localparam logic [31:0]        Q_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0]        Q_MIN     = 32'h8000_0000;
  localparam logic signed [63:0] W_MAX     = 64'sd2147483647;
  localparam logic signed [63:0] W_MIN     = -64'sd2147483648;
  localparam logic [30:0]        THR_RESET = 31'd7;
  localparam int                 SQRT_STEPS = 32;
  localparam int                 DIV_STEPS  = 48;

  typedef struct packed {
    logic [31:0] v;
    logic        ovf;
  } sat_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [32:0] rem;
    logic [31:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [47:0] nq;
    logic [31:0] rem;
    logic [31:0] d;
    logic        neg;
    logic        dz;
    logic        nsgn;
    logic        act;
  } div_t;

  typedef struct packed {
    logic [3:0]       op;
    logic             zf;
    logic             err;
    logic [2:0][31:0] res;
    logic [31:0]      sc;
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
  } car_t;

  typedef struct packed {
    logic [3:0]       op;
    logic             zf;
    logic             err;
    logic [2:0][31:0] res;
    logic [31:0]      sc;
  } meta_t;

  function automatic sat_t sat64(input logic signed [63:0] v);
    sat_t r;
    if (v > W_MAX) begin
      r.v   = Q_MAX;
      r.ovf = 1'b1;
    end else if (v < W_MIN) begin
      r.v   = Q_MIN;
      r.ovf = 1'b1;
    end else begin
      r.v   = v[31:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  function automatic sqrt_t sqrt_step(input sqrt_t x);
    sqrt_t       r;
    logic [34:0] rem2;
    logic [34:0] trial;
    r     = x;
    rem2  = {x.rem, x.rad[63:62]};
    trial = {1'b0, x.root, 2'b01};
    if (rem2 >= trial) begin
      r.rem  = 33'(rem2 - trial);
      r.root = {x.root[30:0], 1'b1};
    end else begin
      r.rem  = rem2[32:0];
      r.root = {x.root[30:0], 1'b0};
    end
    r.rad = {x.rad[61:0], 2'b00};
    return r;
  endfunction

  function automatic div_t div_step(input div_t x);
    div_t        r;
    logic [32:0] rem2;
    r    = x;
    rem2 = {x.rem, x.nq[47]};
    if (rem2 >= {1'b0, x.d}) begin
      r.rem = 32'(rem2 - {1'b0, x.d});
      r.nq  = {x.nq[46:0], 1'b1};
    end else begin
      r.rem = rem2[31:0];
      r.nq  = {x.nq[46:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/vector3_alu.sv
`default_nettype none
// Channel   Dir  Handshake                Payload
// config    in   cfg_we_i                 cfg_wdata_i (zero threshold)
// operands  in   in_valid_i / in_ready_o  opcode_i, a_*_i, b_*_i, c_*_i
// results   out  out_valid_o / out_ready_i res_*_o, scalar_out_o, is_zero_o, error_flag_o
//
// One transaction per cycle sustained, while no waiting result stalls the pipeline.
// Three product and sum stages, 33 square root stages, 49 divider stages and the output
// register make 86 registers, the first of which is loaded at the accepting edge.
// Reset clears all stage valid bits and sets the zero threshold to 7.
// When a result waits, the whole pipeline holds and in_ready_o stays low.

module vector3_alu
  import v3a_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [30:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         opcode_i,
  input  logic signed [31:0] a_x_i,
  input  logic signed [31:0] a_y_i,
  input  logic signed [31:0] a_z_i,
  input  logic signed [31:0] b_x_i,
  input  logic signed [31:0] b_y_i,
  input  logic signed [31:0] b_z_i,
  input  logic signed [31:0] c_x_i,
  input  logic signed [31:0] c_y_i,
  input  logic signed [31:0] c_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] res_x_o,
  output logic signed [31:0] res_y_o,
  output logic signed [31:0] res_z_o,
  output logic signed [31:0] scalar_out_o,
  output logic               is_zero_o,
  output logic               error_flag_o
);

  localparam int N_ST = 3 + (SQRT_STEPS + 1) + (DIV_STEPS + 1) + 1;

  logic [30:0]     thr_q;
  logic [N_ST-1:0] vld_q;
  logic            en;

  assign en         = !vld_q[N_ST-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      vld_q <= '0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (en) begin
        vld_q <= {vld_q[N_ST-2:0], in_valid_i};
      end
    end
  end

  // Product stage.
  logic signed [31:0] ain [3];
  logic signed [31:0] bin [3];
  logic signed [31:0] cin [3];
  logic signed [63:0] sqp_d [3];
  logic signed [63:0] m_d [6];
  logic               cross_sel;

  assign ain[0] = a_x_i;
  assign ain[1] = a_y_i;
  assign ain[2] = a_z_i;
  assign bin[0] = b_x_i;
  assign bin[1] = b_y_i;
  assign bin[2] = b_z_i;
  assign cin[0] = c_x_i;
  assign cin[1] = c_y_i;
  assign cin[2] = c_z_i;

  assign cross_sel = (opcode_i == OP_CROSS) || (opcode_i == OP_TRIPLE) ||
                     (opcode_i == OP_STRIPLE);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqp_d[i] = ain[i] * ain[i];
    end
    m_d[0] = cross_sel ? ain[1] * bin[2] : ain[0] * bin[0];
    m_d[1] = cross_sel ? bin[1] * ain[2] : ain[1] * bin[1];
    m_d[2] = cross_sel ? ain[2] * bin[0] : ain[2] * bin[2];
    m_d[3] = bin[2] * ain[0];
    m_d[4] = ain[0] * bin[1];
    m_d[5] = bin[0] * ain[1];
  end

  logic [3:0]         op1_q;
  logic signed [31:0] a1_q [3];
  logic signed [31:0] b1_q [3];
  logic signed [31:0] c1_q [3];
  logic signed [63:0] sqp1_q [3];
  logic signed [63:0] m1_q [6];

  // Sum and saturate stage.
  logic [47:0]        sq2_d;
  logic               zf2_d;
  logic               err2_d;
  logic signed [31:0] res2_d [3];
  logic signed [31:0] sc2_d;
  logic signed [31:0] t2_d [3];

  always_comb begin
    sat_t               s;
    logic signed [63:0] f [6];
    logic               tovf;
    tovf = 1'b0;
    for (int i = 0; i < 6; i++) begin
      f[i] = m1_q[i] >>> 16;
    end
    for (int i = 0; i < 3; i++) begin
      s       = sat64(f[2*i] - f[2*i+1]);
      t2_d[i] = s.v;
      tovf    = tovf | s.ovf;
    end
    sq2_d = 48'(sqp1_q[0] >>> 16) + 48'(sqp1_q[1] >>> 16) + 48'(sqp1_q[2] >>> 16);
    zf2_d = sq2_d < 48'(thr_q);
    res2_d = '{default: '0};
    sc2_d  = '0;
    err2_d = 1'b0;
    case (op1_q)
      OP_ADD: begin
        for (int i = 0; i < 3; i++) begin
          s         = sat64(64'(a1_q[i]) + 64'(b1_q[i]));
          res2_d[i] = s.v;
          err2_d    = err2_d | s.ovf;
        end
      end
      OP_SUB: begin
        for (int i = 0; i < 3; i++) begin
          s         = sat64(64'(a1_q[i]) - 64'(b1_q[i]));
          res2_d[i] = s.v;
          err2_d    = err2_d | s.ovf;
        end
      end
      OP_MUL: begin
        for (int i = 0; i < 3; i++) begin
          s         = sat64(f[i]);
          res2_d[i] = s.v;
          err2_d    = err2_d | s.ovf;
        end
      end
      OP_DOT: begin
        s      = sat64(f[0] + f[1] + f[2]);
        sc2_d  = s.v;
        err2_d = s.ovf;
      end
      OP_CROSS: begin
        res2_d = t2_d;
        err2_d = tovf;
      end
      OP_LENSQ: begin
        s      = sat64(64'(sq2_d));
        sc2_d  = s.v;
        err2_d = s.ovf;
      end
      OP_DIV, OP_LEN, OP_NORM, OP_ISZERO: begin
        err2_d = 1'b0;
      end
      OP_TRIPLE, OP_STRIPLE: begin
        err2_d = tovf;
      end
      default: begin
        err2_d = 1'b1;
      end
    endcase
  end

  logic [3:0]         op2_q;
  logic [47:0]        sq2_q;
  logic               zf2_q;
  logic               err2_q;
  logic signed [31:0] res2_q [3];
  logic signed [31:0] sc2_q;
  logic signed [31:0] t2_q [3];
  logic signed [31:0] a2_q [3];
  logic signed [31:0] b2_q [3];
  logic signed [31:0] c2_q [3];

  // Second product stage for the chained operations.
  logic               str_sel;
  logic signed [63:0] n3_d [6];

  assign str_sel = (op2_q == OP_STRIPLE);

  always_comb begin
    n3_d[0] = str_sel ? c2_q[0] * t2_q[0] : b2_q[1] * t2_q[2];
    n3_d[1] = str_sel ? c2_q[1] * t2_q[1] : t2_q[1] * b2_q[2];
    n3_d[2] = str_sel ? c2_q[2] * t2_q[2] : b2_q[2] * t2_q[0];
    n3_d[3] = t2_q[2] * b2_q[0];
    n3_d[4] = b2_q[0] * t2_q[1];
    n3_d[5] = t2_q[0] * b2_q[1];
  end

  logic [3:0]         op3_q;
  logic [47:0]        sq3_q;
  logic               zf3_q;
  logic               err3_q;
  logic signed [31:0] res3_q [3];
  logic signed [31:0] sc3_q;
  logic signed [31:0] a3_q [3];
  logic signed [31:0] b3_q [3];
  logic signed [63:0] n3_q [6];

  // Chained result stage, which also seeds the square root.
  car_t  kc_d;
  sqrt_t ks_d;

  always_comb begin
    sat_t               s;
    logic signed [63:0] g [6];
    s = '0;
    for (int i = 0; i < 6; i++) begin
      g[i] = n3_q[i] >>> 16;
    end
    kc_d.op  = op3_q;
    kc_d.zf  = zf3_q;
    kc_d.err = err3_q;
    kc_d.sc  = sc3_q;
    for (int i = 0; i < 3; i++) begin
      kc_d.res[i] = res3_q[i];
      kc_d.a[i]   = a3_q[i];
      kc_d.b[i]   = b3_q[i];
    end
    if (op3_q == OP_TRIPLE) begin
      for (int i = 0; i < 3; i++) begin
        s           = sat64(g[2*i] - g[2*i+1]);
        kc_d.res[i] = s.v;
        kc_d.err    = kc_d.err | s.ovf;
      end
    end
    if (op3_q == OP_STRIPLE) begin
      s        = sat64(g[0] + g[1] + g[2]);
      kc_d.sc  = s.v;
      kc_d.err = kc_d.err | s.ovf;
    end
    ks_d.rad  = {sq3_q, 16'b0};
    ks_d.rem  = '0;
    ks_d.root = '0;
  end

  sqrt_t ks_q [SQRT_STEPS+1];
  car_t  kc_q [SQRT_STEPS+1];

  // Divider setup stage.
  meta_t md_d;
  div_t  dv_d [3];

  always_comb begin
    sat_t        s;
    car_t        car;
    logic [31:0] len;
    logic        norm_go;
    logic [31:0] nv;
    logic [32:0] dv;
    logic [32:0] dabs;
    s       = '0;
    car     = kc_q[SQRT_STEPS];
    len     = ks_q[SQRT_STEPS].root;
    md_d.op  = car.op;
    md_d.zf  = car.zf;
    md_d.err = car.err;
    md_d.res = car.res;
    md_d.sc  = car.sc;
    if (car.op == OP_LEN) begin
      s        = sat64(64'(len));
      md_d.sc  = s.v;
      md_d.err = car.err | s.ovf;
    end
    if ((car.op == OP_NORM) && !car.zf && (len == '0)) begin
      md_d.err = 1'b1;
    end
    norm_go = (car.op == OP_NORM) && !car.zf && (len != '0);
    for (int i = 0; i < 3; i++) begin
      nv   = car.a[i];
      dv   = (car.op == OP_DIV) ? {car.b[i][31], car.b[i]} : {1'b0, len};
      dabs = dv[32] ? (~dv + 33'd1) : dv;
      dv_d[i].nq   = {(nv[31] ? (~nv + 32'd1) : nv), 16'b0};
      dv_d[i].rem  = '0;
      dv_d[i].d    = dabs[31:0];
      dv_d[i].neg  = nv[31] ^ dv[32];
      dv_d[i].dz   = (dabs[31:0] == '0);
      dv_d[i].nsgn = nv[31];
      dv_d[i].act  = (car.op == OP_DIV) || norm_go;
    end
  end

  div_t  dv_q [DIV_STEPS+1][3];
  meta_t mt_q [DIV_STEPS+1];

  // Final sign, saturation and output stage.
  meta_t out_d;
  meta_t out_q;

  always_comb begin
    sat_t               s;
    div_t               dl;
    logic signed [63:0] v;
    s     = '0;
    out_d = mt_q[DIV_STEPS];
    for (int i = 0; i < 3; i++) begin
      dl = dv_q[DIV_STEPS][i];
      v  = $signed({16'b0, dl.nq});
      if (dl.act) begin
        if (dl.dz) begin
          out_d.res[i] = dl.nsgn ? Q_MIN : Q_MAX;
          out_d.err    = 1'b1;
        end else begin
          s            = sat64(dl.neg ? -v : v);
          out_d.res[i] = s.v;
          out_d.err    = out_d.err | s.ovf;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q  <= opcode_i;
      a1_q   <= ain;
      b1_q   <= bin;
      c1_q   <= cin;
      sqp1_q <= sqp_d;
      m1_q   <= m_d;

      op2_q  <= op1_q;
      sq2_q  <= sq2_d;
      zf2_q  <= zf2_d;
      err2_q <= err2_d;
      res2_q <= res2_d;
      sc2_q  <= sc2_d;
      t2_q   <= t2_d;
      a2_q   <= a1_q;
      b2_q   <= b1_q;
      c2_q   <= c1_q;

      op3_q  <= op2_q;
      sq3_q  <= sq2_q;
      zf3_q  <= zf2_q;
      err3_q <= err2_q;
      res3_q <= res2_q;
      sc3_q  <= sc2_q;
      a3_q   <= a2_q;
      b3_q   <= b2_q;
      n3_q   <= n3_d;

      ks_q[0] <= ks_d;
      kc_q[0] <= kc_d;
      for (int j = 1; j <= SQRT_STEPS; j++) begin
        ks_q[j] <= sqrt_step(ks_q[j-1]);
        kc_q[j] <= kc_q[j-1];
      end

      mt_q[0] <= md_d;
      dv_q[0] <= dv_d;
      for (int j = 1; j <= DIV_STEPS; j++) begin
        mt_q[j] <= mt_q[j-1];
        for (int i = 0; i < 3; i++) begin
          dv_q[j][i] <= div_step(dv_q[j-1][i]);
        end
      end

      out_q <= out_d;
    end
  end

  assign out_valid_o  = vld_q[N_ST-1];
  assign res_x_o      = out_q.res[0];
  assign res_y_o      = out_q.res[1];
  assign res_z_o      = out_q.res[2];
  assign scalar_out_o = out_q.sc;
  assign is_zero_o    = out_q.zf;
  assign error_flag_o = out_q.err;

endmodule

`default_nettype wire

### sim/vector3_alu_test.sv
`timescale 1ns / 1ps

module vector3_alu_test;
  import v3a_pkg::*;

  typedef logic signed [63:0] wide_t;
  typedef wide_t wvec_t [3];

  typedef struct packed {
    logic [3:0]       op;
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    logic [2:0][31:0] c;
  } operands_t;

  typedef struct packed {
    logic [2:0][31:0] res;
    logic [31:0]      sc;
    logic             zf;
    logic             err;
  } vec_result_t;

  localparam logic [3:0] OP_UNDEF_FIRST = 4'd12;
  localparam logic [3:0] OP_UNDEF_LAST  = 4'd15;
  localparam logic [31:0] Q_ONE_BITS = 32'h0001_0000;
  localparam int STALL_LIMIT = 3000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [30:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  operands_t cur = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] res_x, res_y, res_z, scalar_out;
  logic is_zero, error_flag;

  operands_t pending_ops[$];
  vec_result_t expected_results[$];
  logic [30:0] thr_model = THR_RESET;
  int errors = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int no_gap_run = 0;
  int idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  vector3_alu uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .opcode_i(cur.op),
    .a_x_i(cur.a[0]), .a_y_i(cur.a[1]), .a_z_i(cur.a[2]),
    .b_x_i(cur.b[0]), .b_y_i(cur.b[1]), .b_z_i(cur.b[2]),
    .c_x_i(cur.c[0]), .c_y_i(cur.c[1]), .c_z_i(cur.c[2]),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .res_x_o(res_x), .res_y_o(res_y), .res_z_o(res_z),
    .scalar_out_o(scalar_out), .is_zero_o(is_zero), .error_flag_o(error_flag)
  );

  function automatic wide_t fxmul(wide_t x, wide_t y);
    return (x * y) >>> 16;
  endfunction

  function automatic wide_t saturate(wide_t v, inout logic err);
    if (v > W_MAX) begin
      err = 1'b1;
      return W_MAX;
    end
    if (v < W_MIN) begin
      err = 1'b1;
      return W_MIN;
    end
    return v;
  endfunction

  function automatic wide_t fxdiv(wide_t n, wide_t d, inout logic err);
    if (d == 0) begin
      err = 1'b1;
      return (n >= 0) ? W_MAX : W_MIN;
    end
    return saturate((n * 65536) / d, err);
  endfunction

  function automatic wide_t dot3(wvec_t u, wvec_t v);
    return fxmul(u[0], v[0]) + fxmul(u[1], v[1]) + fxmul(u[2], v[2]);
  endfunction

  function automatic void cross3(input wvec_t u, input wvec_t v, output wvec_t r,
                                 inout logic err);
    r[0] = saturate(fxmul(u[1], v[2]) - fxmul(v[1], u[2]), err);
    r[1] = saturate(fxmul(u[2], v[0]) - fxmul(v[2], u[0]), err);
    r[2] = saturate(fxmul(u[0], v[1]) - fxmul(v[0], u[1]), err);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitpos;
    root = 0;
    bitpos = 64'd1 << 62;
    while (bitpos > n) bitpos = bitpos >> 2;
    while (bitpos != 0) begin
      if (n >= root + bitpos) begin
        n = n - (root + bitpos);
        root = (root >> 1) + bitpos;
      end else begin
        root = root >> 1;
      end
      bitpos = bitpos >> 2;
    end
    return root;
  endfunction

  function automatic vec_result_t vector_alu_predict(operands_t t, logic [30:0] thr);
    wvec_t a, b, c, tmp, r;
    wide_t sq, len, sc;
    logic err;
    logic zf;
    vec_result_t o;
    for (int i = 0; i < 3; i++) begin
      a[i] = wide_t'($signed(t.a[i]));
      b[i] = wide_t'($signed(t.b[i]));
      c[i] = wide_t'($signed(t.c[i]));
      r[i] = 0;
    end
    sc = 0;
    err = 1'b0;
    sq = dot3(a, a);
    zf = sq < $signed({33'd0, thr});
    len = $signed(int_sqrt(64'(sq) << 16));
    case (t.op)
      OP_ADD: for (int i = 0; i < 3; i++) r[i] = saturate(a[i] + b[i], err);
      OP_SUB: for (int i = 0; i < 3; i++) r[i] = saturate(a[i] - b[i], err);
      OP_MUL: for (int i = 0; i < 3; i++) r[i] = saturate(fxmul(a[i], b[i]), err);
      OP_DIV: for (int i = 0; i < 3; i++) r[i] = fxdiv(a[i], b[i], err);
      OP_DOT: sc = saturate(dot3(a, b), err);
      OP_CROSS: cross3(a, b, r, err);
      OP_LENSQ: sc = saturate(sq, err);
      OP_LEN: sc = saturate(len, err);
      OP_NORM: begin
        if (!zf) begin
          if (len == 0) err = 1'b1;
          else for (int i = 0; i < 3; i++) r[i] = fxdiv(a[i], len, err);
        end
      end
      OP_ISZERO: ;
      OP_TRIPLE: begin
        cross3(a, b, tmp, err);
        cross3(b, tmp, r, err);
      end
      OP_STRIPLE: begin
        cross3(a, b, tmp, err);
        sc = saturate(dot3(c, tmp), err);
      end
      default: err = 1'b1;
    endcase
    for (int i = 0; i < 3; i++) o.res[i] = r[i][31:0];
    o.sc = sc[31:0];
    o.zf = zf;
    o.err = err;
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] rand_fixed();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3, 4, 5: return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
      6: return 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
      7: return 32'($urandom_range(0, 15)) - 32'd8;
      default: begin
        case ($urandom_range(0, 5))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return '0;
          3: return Q_ONE_BITS;
          4: return -Q_ONE_BITS;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  function automatic operands_t rand_operands();
    operands_t t;
    if ($urandom_range(0, 19) == 0) t.op = 4'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
    else t.op = 4'($urandom_range(OP_ADD, OP_STRIPLE));
    for (int i = 0; i < 3; i++) begin
      t.a[i] = rand_fixed();
      t.b[i] = rand_fixed();
      t.c[i] = rand_fixed();
    end
    if ($urandom_range(0, 9) == 0) t.b[$urandom_range(0, 2)] = '0;
    return t;
  endfunction

  function automatic operands_t make_op(logic [3:0] op, logic [31:0] av, logic [31:0] bv,
                                        logic [31:0] cv);
    operands_t t;
    t.op = op;
    for (int i = 0; i < 3; i++) begin
      t.a[i] = av;
      t.b[i] = bv;
      t.c[i] = cv;
    end
    return t;
  endfunction

  // Driver: presents queued operands and predicts each accepted transaction.
  always @(posedge clk_i) begin
    operands_t nxt;
    logic drive;
    if (rst_ni) begin
      drive = in_valid;
      nxt = cur;
      if (in_valid && in_ready) begin
        expected_results.push_back(vector_alu_predict(cur, thr_model));
        drive = 1'b0;
      end
      if (!drive) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_ops.size() > 0) begin
          nxt = pending_ops.pop_front();
          drive = 1'b1;
          if (no_gap_run > 0) no_gap_run <= no_gap_run - 1;
          else if ($urandom_range(0, 49) == 0) no_gap_run <= $urandom_range(20, 60);
          else send_gap <= pick_gap();
        end
      end
      in_valid <= drive;
      cur <= nxt;
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // Monitor: checks every result transaction against the oldest prediction.
  always @(posedge clk_i) begin
    vec_result_t e;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result transaction, actual %h %h %h %h %b %b", $time,
                   res_x, res_y, res_z, scalar_out, is_zero, error_flag);
        end else begin
          e = expected_results.pop_front();
          check_field("res_x", e.res[0], res_x);
          check_field("res_y", e.res[1], res_y);
          check_field("res_z", e.res[2], res_z);
          check_field("scalar_out", e.sc, scalar_out);
          check_field("is_zero", 32'(e.zf), 32'(is_zero));
          check_field("error_flag", 32'(e.err), 32'(error_flag));
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if (out_ready && $urandom_range(0, 3) == 0) begin
        recv_gap <= pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (pending_ops.size() > 0 || in_valid || send_gap > 0 || expected_results.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [30:0] v);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    thr_model = v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_random(int n);
    for (int k = 0; k < n; k++) pending_ops.push_back(rand_operands());
  endtask

  initial begin
    operands_t t;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int op = 0; op <= OP_UNDEF_LAST; op++)
      pending_ops.push_back(make_op(4'(op), Q_ONE_BITS, 32'h0002_8000, 32'hFFFF_0000));
    pending_ops.push_back(make_op(OP_ADD, Q_MAX, Q_MAX, '0));
    pending_ops.push_back(make_op(OP_SUB, Q_MIN, Q_MAX, '0));
    pending_ops.push_back(make_op(OP_MUL, Q_MIN, Q_MIN, '0));
    pending_ops.push_back(make_op(OP_DIV, Q_ONE_BITS, '0, '0));
    pending_ops.push_back(make_op(OP_DIV, -Q_ONE_BITS, '0, '0));
    pending_ops.push_back(make_op(OP_NORM, 32'd1, Q_MAX, '0));
    pending_ops.push_back(make_op(OP_STRIPLE, Q_MAX, Q_MIN, Q_MAX));
    t = make_op(OP_TRIPLE, Q_MAX, Q_MIN, '0);
    t.a[1] = Q_MIN;
    pending_ops.push_back(t);
    wait_drained();

    write_threshold('0);
    pending_ops.push_back(make_op(OP_NORM, '0, '0, '0));
    pending_ops.push_back(make_op(OP_NORM, 32'd1, '0, '0));
    pending_ops.push_back(make_op(OP_LEN, Q_MIN, '0, '0));
    queue_random(200);
    wait_drained();

    write_threshold(31'h7FFF_FFFF);
    queue_random(150);
    wait_drained();

    write_threshold(31'h0001_0000);
    queue_random(250);
    wait_drained();

    write_threshold(31'($urandom));
    queue_random(250);
    wait_drained();

    repeat (100) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
